FILE: hw/rtl/nrac_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrac_pkg
// Shared codes, types and the NAL header decode for the random-access
// classifier.
// ----------------------------------------------------------------------------
package nrac_pkg;

  localparam logic [1:0] CODEC_H264 = 2'd0;
  localparam logic [1:0] CODEC_HEVC = 2'd1;

  localparam logic [2:0] CNT_SAT  = 3'd5;
  localparam logic [2:0] CNT_LAST = 3'd3;

  localparam logic [5:0] H264_IDR       = 6'd5;
  localparam logic [5:0] H264_VCL_MIN   = 6'd1;
  localparam logic [5:0] HEVC_VCL_MAX   = 6'd31;
  localparam logic [5:0] HEVC_IRAP_MIN  = 6'd16;
  localparam logic [5:0] HEVC_IRAP_MAX  = 6'd20;
  localparam logic [5:0] HEVC_RASL_N    = 6'd8;
  localparam logic [5:0] HEVC_RASL_R    = 6'd9;

  // Length-prefix walker phase
  typedef enum logic [2:0] {
    PH_LEN0,
    PH_LEN1,
    PH_LEN2,
    PH_LEN3,
    PH_HDR,
    PH_SKIP
  } phase_e;

  typedef struct packed {
    logic       vcl;
    logic [5:0] ty;
  } hdr_t;

  // Type a NAL header byte; vcl is set for slice NAL units.
  function automatic hdr_t decode_hdr(logic [7:0] hdr, logic [1:0] codec);
    hdr_t r;
    r.vcl = 1'b0;
    r.ty  = '0;
    priority if (codec == CODEC_HEVC) begin
      r.ty  = hdr[6:1];
      r.vcl = (r.ty <= HEVC_VCL_MAX);
    end else if (codec == CODEC_H264) begin
      r.ty  = {1'b0, hdr[4:0]};
      r.vcl = (r.ty >= H264_VCL_MIN) && (r.ty <= H264_IDR);
    end else begin
      r.ty  = '0;
      r.vcl = 1'b0;
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/nal_random_access_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nal_random_access_classifier
// Classifies an H.264 / HEVC packet as IDR/BLA or RASL, one byte per word.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel carries one packet byte per word with first/last markers,
//   the codec and the container keyframe flag. A word is taken when
//   in_valid_i is high and in_stall_o is low. One byte per cycle is
//   sustained while the receiver does not stall; the per-byte parser update is
//   a single registered pass. Only the word marked last produces a result word
//   on the output channel (is_idr, is_rasl, vcl_found, vcl_nal_type), after it
//   passes through the input register and then the result register.
//   When the receiver stalls with a result pending, the whole pipe holds and
//   in_stall_o rises in the same cycle; nothing is dropped.
//   Reset clears all parser state and both valid flags; the block is ready
//   as soon as rst_ni rises. A word with the first marker
//   restarts the packet; a word after a last one starts a new packet.
// ----------------------------------------------------------------------------
module nal_random_access_classifier (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       first_byte_i,
  input  logic       last_byte_i,
  input  logic [1:0] codec_i,
  input  logic       keyframe_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       is_idr_o,
  output logic       is_rasl_o,
  output logic       vcl_found_o,
  output logic [5:0] vcl_nal_type_o
);

  logic advance;

  // Input register
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_first_q;
  logic       s1_last_q;
  logic [1:0] s1_codec_q;
  logic       s1_key_q;

  // Parser state
  logic [2:0]       byte_cnt_q, byte_cnt_d;
  logic [23:0]      lead_q, lead_d;
  logic             annexb_q, annexb_d;
  logic [1:0]       zero_run_q, zero_run_d;
  logic             hdr_next_q, hdr_next_d;
  nrac_pkg::phase_e phase_q, phase_d;
  logic [31:0]      plen_q, plen_d;
  logic [31:0]      skip_q, skip_d;
  logic             stopped_q, stopped_d;
  logic             sfound_q, sfound_d;
  logic [5:0]       stype_q, stype_d;
  logic             wfound_q, wfound_d;
  logic [5:0]       wtype_q, wtype_d;

  // Result register
  logic       out_valid_q, out_valid_d;
  logic       idr_q, idr_d;
  logic       rasl_q, rasl_d;
  logic       found_q, found_d;
  logic [5:0] type_q, type_d;

  nrac_pkg::hdr_t hdr_dec;
  logic [31:0]    skip_hdr;
  logic [31:0]    plen_sh;

  assign advance    = !(out_valid_q && out_stall_i);
  assign in_stall_o = !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_i) begin
      s1_byte_q  <= data_byte_i;
      s1_first_q <= first_byte_i;
      s1_last_q  <= last_byte_i;
      s1_codec_q <= codec_i;
      s1_key_q   <= keyframe_i;
    end
  end

  assign hdr_dec = nrac_pkg::decode_hdr(s1_byte_q, s1_codec_q);

  always_comb begin
    // Restart on the first marker, then update with this byte
    byte_cnt_d = s1_first_q ? '0 : byte_cnt_q;
    lead_d     = s1_first_q ? '0 : lead_q;
    annexb_d   = s1_first_q ? 1'b0 : annexb_q;
    zero_run_d = s1_first_q ? '0 : zero_run_q;
    hdr_next_d = s1_first_q ? 1'b0 : hdr_next_q;
    phase_d    = s1_first_q ? nrac_pkg::PH_LEN0 : phase_q;
    plen_d     = s1_first_q ? '0 : plen_q;
    skip_d     = s1_first_q ? '0 : skip_q;
    stopped_d  = s1_first_q ? 1'b0 : stopped_q;
    sfound_d   = s1_first_q ? 1'b0 : sfound_q;
    stype_d    = s1_first_q ? '0 : stype_q;
    wfound_d   = s1_first_q ? 1'b0 : wfound_q;
    wtype_d    = s1_first_q ? '0 : wtype_q;

    // Lead bytes decide Annex B versus length prefixes
    if (byte_cnt_d < nrac_pkg::CNT_LAST) begin
      lead_d = {lead_d[15:0], s1_byte_q};
    end else if (byte_cnt_d == nrac_pkg::CNT_LAST) begin
      annexb_d = (lead_d[23:16] == 8'd0) && (lead_d[15:8] == 8'd0) &&
                 ((lead_d[7:0] == 8'd1) || ((lead_d[7:0] == 8'd0) && (s1_byte_q == 8'd1)));
    end
    if (byte_cnt_d < nrac_pkg::CNT_SAT) begin
      byte_cnt_d = byte_cnt_d + 3'd1;
    end

    // Start-code scanner
    if (!sfound_d) begin
      priority if (hdr_next_d) begin
        hdr_next_d = 1'b0;
        zero_run_d = '0;
        if (hdr_dec.vcl) begin
          sfound_d = 1'b1;
          stype_d  = hdr_dec.ty;
        end
      end else if (s1_byte_q == 8'd0) begin
        if (zero_run_d < 2'd2) begin
          zero_run_d = zero_run_d + 2'd1;
        end
      end else if (s1_byte_q == 8'd1 && zero_run_d == 2'd2) begin
        hdr_next_d = 1'b1;
        zero_run_d = '0;
      end else begin
        zero_run_d = '0;
      end
    end

    // Length-prefix walker
    plen_sh  = {plen_d[23:0], s1_byte_q};
    skip_hdr = plen_d - 32'd1;
    if (!wfound_d && !stopped_d) begin
      unique case (phase_d)
        nrac_pkg::PH_LEN0, nrac_pkg::PH_LEN1, nrac_pkg::PH_LEN2: begin
          plen_d  = plen_sh;
          phase_d = nrac_pkg::phase_e'(phase_d + 3'd1);
        end
        nrac_pkg::PH_LEN3: begin
          plen_d = plen_sh;
          if (plen_sh == 32'd0) begin
            stopped_d = 1'b1;
          end else begin
            phase_d = nrac_pkg::PH_HDR;
          end
        end
        nrac_pkg::PH_HDR: begin
          if (hdr_dec.vcl) begin
            wfound_d = 1'b1;
            wtype_d  = hdr_dec.ty;
          end
          skip_d  = skip_hdr;
          plen_d  = '0;
          phase_d = (skip_hdr == 32'd0) ? nrac_pkg::PH_LEN0 : nrac_pkg::PH_SKIP;
        end
        default: begin
          if (skip_d != 32'd0) begin
            skip_d = skip_d - 32'd1;
          end
          if (skip_d == 32'd0) begin
            phase_d = nrac_pkg::PH_LEN0;
          end
        end
      endcase
    end
  end

  // Result for the last byte
  always_comb begin
    found_d = 1'b0;
    type_d  = '0;
    if (byte_cnt_d >= nrac_pkg::CNT_SAT &&
        (s1_codec_q == nrac_pkg::CODEC_H264 || s1_codec_q == nrac_pkg::CODEC_HEVC)) begin
      found_d = annexb_d ? sfound_d : wfound_d;
      type_d  = annexb_d ? stype_d : wtype_d;
    end
    if (!found_d) begin
      type_d = '0;
    end

    idr_d  = 1'b0;
    rasl_d = 1'b0;
    if (s1_key_q) begin
      priority if (!found_d || (s1_codec_q != nrac_pkg::CODEC_H264 &&
                                s1_codec_q != nrac_pkg::CODEC_HEVC)) begin
        idr_d = 1'b1;
      end else if (s1_codec_q == nrac_pkg::CODEC_HEVC) begin
        idr_d = (type_d >= nrac_pkg::HEVC_IRAP_MIN) && (type_d <= nrac_pkg::HEVC_IRAP_MAX);
      end else begin
        idr_d = (type_d == nrac_pkg::H264_IDR);
      end
    end else begin
      rasl_d = (s1_codec_q == nrac_pkg::CODEC_HEVC) && found_d &&
               (type_d == nrac_pkg::HEVC_RASL_N || type_d == nrac_pkg::HEVC_RASL_R);
    end

    out_valid_d = s1_valid_q && s1_last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_cnt_q <= '0;
      lead_q     <= '0;
      annexb_q   <= 1'b0;
      zero_run_q <= '0;
      hdr_next_q <= 1'b0;
      phase_q    <= nrac_pkg::PH_LEN0;
      plen_q     <= '0;
      skip_q     <= '0;
      stopped_q  <= 1'b0;
      sfound_q   <= 1'b0;
      stype_q    <= '0;
      wfound_q   <= 1'b0;
      wtype_q    <= '0;
    end else if (advance && s1_valid_q) begin
      if (s1_last_q) begin
        // Packet done: drop all parser state
        byte_cnt_q <= '0;
        lead_q     <= '0;
        annexb_q   <= 1'b0;
        zero_run_q <= '0;
        hdr_next_q <= 1'b0;
        phase_q    <= nrac_pkg::PH_LEN0;
        plen_q     <= '0;
        skip_q     <= '0;
        stopped_q  <= 1'b0;
        sfound_q   <= 1'b0;
        stype_q    <= '0;
        wfound_q   <= 1'b0;
        wtype_q    <= '0;
      end else begin
        byte_cnt_q <= byte_cnt_d;
        lead_q     <= lead_d;
        annexb_q   <= annexb_d;
        zero_run_q <= zero_run_d;
        hdr_next_q <= hdr_next_d;
        phase_q    <= phase_d;
        plen_q     <= plen_d;
        skip_q     <= skip_d;
        stopped_q  <= stopped_d;
        sfound_q   <= sfound_d;
        stype_q    <= stype_d;
        wfound_q   <= wfound_d;
        wtype_q    <= wtype_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && out_valid_d) begin
      idr_q   <= idr_d;
      rasl_q  <= rasl_d;
      found_q <= found_d;
      type_q  <= type_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign is_idr_o       = idr_q;
  assign is_rasl_o      = rasl_q;
  assign vcl_found_o    = found_q;
  assign vcl_nal_type_o = type_q;

  a_idr_rasl_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(is_idr_o && is_rasl_o))
    else $error("is_idr and is_rasl both set");

  a_type_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !vcl_found_o) |-> (vcl_nal_type_o == 6'd0))
    else $error("type nonzero without a VCL");

  a_rasl_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_rasl_o) |-> vcl_found_o)
    else $error("RASL reported without a VCL");

  a_cnt_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_cnt_q <= nrac_pkg::CNT_SAT)
    else $error("byte count past saturation");

  a_skip_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == nrac_pkg::PH_SKIP) |-> (skip_q != 32'd0))
    else $error("skip phase with nothing to skip");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> in_stall_o)
    else $error("input taken while result blocked");

endmodule
